// ----- rtl/core/erpm_pkg.sv -----
// ----------------------------------------------------------------------------
// erpm_pkg: shared types, widths and helpers for the encoder rpm estimator
// Item structs, sequencer phases, config indexes and saturation functions.
// ----------------------------------------------------------------------------
package erpm_pkg;

  // fixed-point fraction bits of the instant and smoothed speed
  localparam int FracBits = 16;

  localparam int CountW = 32;
  localparam int TimeW  = 32;
  localparam int CfgW   = 16;
  localparam int KeepW  = 16;             // smoothing weight, Q0.16
  localparam int NumW   = CountW + 16;    // |delta| * 60000
  localparam int DenW   = CfgW + TimeW;   // ticks per turn * elapsed ms
  localparam int QuoW   = NumW + FracBits;
  localparam int QiW    = QuoW - FracBits; // integer part of the quotient
  localparam int SpdW   = 48;             // smoothed speed register
  localparam int QmagW  = SpdW - 1;       // saturated speed magnitude
  localparam int ErrW   = SpdW + 1;       // smoothed minus instant speed
  localparam int AccW   = ErrW + 1;
  localparam int AluW   = AccW + 1;
  localparam int CntW   = $clog2(QuoW);
  localparam int CfgIdxW = 1;

  localparam logic [15:0]      RpmScale = 16'd60000;
  localparam logic [QmagW-1:0] SpeedMax = {QmagW{1'b1}};
  localparam logic [CfgW-1:0]  CprReset  = 16'd1;
  localparam logic [KeepW-1:0] KeepReset = 16'd62259;

  localparam logic [CfgIdxW-1:0] CfgCountsPerRev = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSmoothingKeep = 1'b1;

  typedef struct packed {
    logic signed [CountW-1:0] encoder_count;
    logic [TimeW-1:0]         now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rpm;
    logic signed [31:0] smoothed_rpm;
    logic               zero_interval;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_MUL,
    ST_DIV,
    ST_ERR,
    ST_MAC,
    ST_UPD,
    ST_FIN
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   take_in;
    logic   load_out;
  } ctl_t;

  // sign and magnitude to 32-bit signed, saturated
  function automatic logic [31:0] sat_sm32(input logic neg, input logic [QiW-1:0] mag);
    logic [31:0] res;
    if (neg) begin
      if (mag > QiW'(33'h1_0000_0000 >> 1)) begin
        res = 32'h8000_0000;
      end else begin
        res = 32'(0) - mag[31:0];
      end
    end else begin
      if (mag > QiW'(32'h7FFF_FFFF)) begin
        res = 32'h7FFF_FFFF;
      end else begin
        res = mag[31:0];
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] sat_s32(input logic signed [63:0] v);
    logic [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/encoder_rpm_estimator.sv -----
// ----------------------------------------------------------------------------
// encoder_rpm_estimator: wheel speed and smoothed speed from encoder samples
// Config registers, sequencer and datapath around one shared add/sub unit.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake               | payload
//   cfg      | in        | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//   in       | in        | in_valid_i / in_ready_o | in_item_t
//   out      | out       | out_valid_o/out_ready_i | out_item_t
//
// After an input transfer the block is busy and takes no new transfer until
// its result is loaded: 64 divider steps (one quotient bit each) and 16
// shift-add steps of the smoothing multiply share one adder, plus the ABS,
// MUL, ERR, UPD and FIN phases and the idle phase that takes the next
// transfer. A zero interval skips both loops.
// The result sits in an output register; the sequencer waits in its last
// phase only while that register still holds an untaken result.
// Reset is asynchronous, active low; no clearing pass.
module encoder_rpm_estimator import erpm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o
);

  logic [CfgW-1:0]  cpr_q;
  logic [KeepW-1:0] keep_q;
  ctl_t             ctl;
  logic             zero_dt;
  logic             out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q  <= CprReset;
      keep_q <= KeepReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCountsPerRev:  cpr_q  <= cfg_wdata_i;
        CfgSmoothingKeep: keep_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_valid_o || out_ready_i;

  erpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .zero_dt_i  (zero_dt),
    .out_free_i (out_free),
    .ctl_o      (ctl)
  );

  erpm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .in_data_i   (in_data_i),
    .cpr_i       (cpr_q),
    .keep_i      (keep_q),
    .zero_dt_o   (zero_dt),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready stayed high after input transfer");

  // zero interval results carry no instant speed
  a_zero_rpm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_interval) |-> (out_data_o.rpm == 32'sd0))
    else $error("nonzero rpm on zero interval");

  // a result is loaded only when the output register is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.load_out) |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten");

endmodule

// ----- rtl/core/erpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// erpm_ctrl: sequencer of the encoder rpm estimator
// Steps one item through delta, multiply, divide, smoothing and result load; a zero interval goes straight to the load.
// ----------------------------------------------------------------------------
module erpm_ctrl import erpm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic zero_dt_i,
  input  logic out_free_i,
  output ctl_t ctl_o
);

  phase_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_ABS;
      end
      ST_ABS: begin
        state_d = zero_dt_i ? ST_FIN : ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_DIV;
        cnt_d   = '0;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(QuoW - 1)) state_d = ST_ERR;
      end
      ST_ERR: begin
        state_d = ST_MAC;
        cnt_d   = '0;
      end
      ST_MAC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(KeepW - 1)) state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    ctl_o.phase    = state_q;
    ctl_o.take_in  = (state_q == ST_IDLE) && in_valid_i;
    ctl_o.load_out = (state_q == ST_FIN) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/erpm_datapath.sv -----
// ----------------------------------------------------------------------------
// erpm_datapath: registers and shared add/sub unit of the rpm estimator
// Restoring divider, shift-add smoothing multiply and output register.
// ----------------------------------------------------------------------------
module erpm_datapath import erpm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctl_t            ctl_i,
  input  in_item_t        in_data_i,
  input  logic [CfgW-1:0]  cpr_i,
  input  logic [KeepW-1:0] keep_i,
  output logic            zero_dt_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output out_item_t       out_data_o
);

  // state
  logic [CountW-1:0]        last_count_q;
  logic [TimeW-1:0]         last_time_q;
  logic signed [SpdW-1:0]   smooth_q;
  logic                     out_valid_q;

  // per-item working registers
  logic [CountW-1:0]        diff_q;
  logic [TimeW-1:0]         dt_q;
  logic                     neg_q;
  logic [DenW-1:0]          den_q;
  logic [QuoW-1:0]          quo_q;
  logic [DenW-1:0]          rem_q;
  logic [ErrW-1:0]          err_q;
  logic [AccW-1:0]          acc_q;
  logic [KeepW-1:0]         keep_sh_q;
  out_item_t                out_q;

  logic [CfgW-1:0]          cpr_eff;
  logic                     qsat;
  logic [QmagW-1:0]         qmag;
  logic [DenW:0]            shifted;
  logic [AluW-1:0]          alu_a, alu_b, alu_sum;
  logic                     alu_sub;
  logic                     borrow;
  logic [NumW-1:0]          num;
  logic signed [63:0]       s_ext, s_tr;
  logic                     s_rnd;

  assign cpr_eff   = (cpr_i == '0) ? CfgW'(1) : cpr_i;
  assign zero_dt_o = (dt_q == '0);
  assign qsat      = |quo_q[QuoW-1:QmagW];
  assign qmag      = qsat ? SpeedMax : quo_q[QmagW-1:0];
  assign shifted   = {rem_q, quo_q[QuoW-1]};
  assign num       = NumW'(diff_q) * NumW'(RpmScale);

  // shared add/sub unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (ctl_i.phase)
      ST_DIV: begin
        alu_a   = {{(AluW-DenW-1){1'b0}}, shifted};
        alu_b   = {{(AluW-DenW){1'b0}}, den_q};
        alu_sub = 1'b1;
      end
      ST_ERR: begin
        // smoothed - signed instant speed
        alu_a   = {{(AluW-SpdW){smooth_q[SpdW-1]}}, smooth_q};
        alu_b   = {{(AluW-QmagW){1'b0}}, qmag};
        alu_sub = !neg_q;
      end
      ST_MAC: begin
        alu_a   = {{(AluW-AccW){acc_q[AccW-1]}}, acc_q};
        alu_b   = keep_sh_q[0] ? {{(AluW-ErrW){err_q[ErrW-1]}}, err_q} : '0;
      end
      ST_UPD: begin
        alu_a   = {{(AluW-AccW){acc_q[AccW-1]}}, acc_q};
        alu_b   = {{(AluW-QmagW){1'b0}}, qmag};
        alu_sub = neg_q;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  assign borrow = alu_sum[AluW-1];

  // smoothed output truncated toward zero
  always_comb begin
    s_ext = 64'(smooth_q);
    s_rnd = smooth_q[SpdW-1] & (|smooth_q[FracBits-1:0]);
    s_tr  = (s_ext >>> FracBits) + signed'({63'b0, s_rnd});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      last_time_q  <= '0;
      smooth_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ctl_i.take_in) begin
        last_count_q <= in_data_i.encoder_count;
        last_time_q  <= in_data_i.now_ms;
      end
      if (ctl_i.phase == ST_UPD) smooth_q <= alu_sum[SpdW-1:0];
      if (ctl_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take_in) begin
      diff_q <= in_data_i.encoder_count - last_count_q;
      dt_q   <= in_data_i.now_ms - last_time_q;
    end
    unique case (ctl_i.phase)
      ST_ABS: begin
        neg_q  <= diff_q[CountW-1];
        diff_q <= diff_q[CountW-1] ? (CountW'(0) - diff_q) : diff_q;
        den_q  <= DenW'(cpr_eff) * DenW'(dt_q);
      end
      ST_MUL: begin
        quo_q <= {num, {FracBits{1'b0}}};
        rem_q <= '0;
      end
      ST_DIV: begin
        rem_q <= borrow ? shifted[DenW-1:0] : alu_sum[DenW-1:0];
        quo_q <= {quo_q[QuoW-2:0], !borrow};
      end
      ST_ERR: begin
        err_q     <= alu_sum[ErrW-1:0];
        acc_q     <= '0;
        keep_sh_q <= keep_i;
      end
      ST_MAC: begin
        // add, then halve: floor of keep * err / 2^16 after all steps
        acc_q     <= alu_sum[AluW-1:1];
        keep_sh_q <= keep_sh_q >> 1;
      end
      default: begin
      end
    endcase
    if (ctl_i.load_out) begin
      out_q.rpm           <= zero_dt_o ? 32'sd0 : sat_sm32(neg_q, quo_q[QuoW-1:FracBits]);
      out_q.smoothed_rpm  <= sat_s32(s_tr);
      out_q.zero_interval <= zero_dt_o;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
